>>> sv/deq_pkg.sv
package deq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = $clog2(2 * DEPTH);
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic accept;
		logic capture;
		logic load;
	} deq_cmd_t;

	// sum stays below twice the depth, so one compare and subtract wraps it
	function automatic logic [IDX_W-1:0] wrap_index(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] lim;
		lim = SUM_W'(DEPTH);
		if (sum >= lim) begin
			return IDX_W'(sum - lim);
		end
		return IDX_W'(sum);
	endfunction

endpackage

>>> sv/deq_in_if.sv
interface deq_in_if import deq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

>>> sv/deq_out_if.sv
interface deq_out_if import deq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic [CNT_W-1:0]  entry_total;
	logic              is_empty;
	logic              is_full;
	logic [1:0]        status;

	modport source (output valid, output front_value, output back_value, output entry_total,
		output is_empty, output is_full, output status, input ready);
	modport sink (input valid, input front_value, input back_value, input entry_total,
		input is_empty, input is_full, input status, output ready);
endinterface

>>> sv/deq_ctrl.sv
module deq_ctrl import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output deq_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		in_ready    = (state_q == S_IDLE);
		cmd.accept  = in_ready & in_valid;
		cmd.capture = (state_q == S_READ);
		// result moves to the output register once the old one is gone
		cmd.load    = (state_q == S_LOAD) & (~out_valid_q | out_ready);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (cmd.load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/deq_datapath.sv
module deq_datapath import deq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  deq_cmd_t                 cmd,
	input  logic [1:0]               operation,
	input  logic signed [DATA_W-1:0] value,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] back_value,
	output logic [CNT_W-1:0]         entry_total,
	output logic                     is_empty,
	output logic                     is_full,
	output logic [1:0]               status
);

	logic [DATA_W-1:0] ring_q [DEPTH];
	logic [IDX_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] rd_front_q;
	logic [DATA_W-1:0] rd_back_q;
	logic signed [DATA_W-1:0] out_front_q;
	logic signed [DATA_W-1:0] out_back_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_empty_q;
	logic              out_full_q;
	logic [1:0]        out_status_q;

	op_t              op;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] tail_addr;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] back_addr;
	logic [IDX_W-1:0] front_nxt;
	logic [CNT_W-1:0] count_nxt;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	status_t          status_nxt;

	always_comb begin
		op         = op_t'(operation);
		full       = (count_q == CNT_W'(DEPTH));
		empty      = (count_q == '0);
		tail_addr  = wrap_index(SUM_W'(front_q) + SUM_W'(count_q));
		front_dec  = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
		front_inc  = wrap_index(SUM_W'(front_q) + SUM_W'(1));
		// wraps to a harmless slot when empty; the value is zeroed then
		back_addr  = wrap_index(SUM_W'(front_q) + SUM_W'(count_q) - SUM_W'(1));
		front_nxt  = front_q;
		count_nxt  = count_q;
		wr_en      = 1'b0;
		wr_addr    = tail_addr;
		status_nxt = ST_DONE;
		case (op)
			OP_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					wr_addr   = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					front_nxt = front_inc;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept & wr_en) begin
			ring_q[wr_addr] <= value;
		end
	end

	// read in the cycle after the update so the new word is seen
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_front_q <= ring_q[front_q];
			rd_back_q  <= ring_q[back_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_q <= status_nxt;
		end
		if (cmd.load) begin
			out_front_q  <= empty ? '0 : rd_front_q;
			out_back_q   <= empty ? '0 : rd_back_q;
			out_count_q  <= count_q;
			out_empty_q  <= empty;
			out_full_q   <= full;
			out_status_q <= status_q;
		end
	end

	assign front_value = out_front_q;
	assign back_value  = out_back_q;
	assign entry_total = out_count_q;
	assign is_empty    = out_empty_q;
	assign is_full     = out_full_q;
	assign status      = out_status_q;

endmodule

>>> sv/double_ended_queue.sv
// channel | dir | fields                                                   | handshake
// req     | in  | operation, value                                         | valid/ready
// rsp     | out | front_value, back_value, entry_total, is_empty, is_full, status | valid/ready
//
// words are taken one at a time: accept updates indices and writes the ring,
// S_READ then reads front and back through the registered ring port,
// and S_LOAD loads the output register before the next word is accepted
// arst_n clears the indices, count and handshake state; the ring needs no clear
// a held result lets one more word be accepted; it waits until rsp is taken
module double_ended_queue import deq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	deq_in_if.sink   req,
	deq_out_if.source rsp
);

	deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	deq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (req.operation),
		.value       (req.value),
		.front_value (rsp.front_value),
		.back_value  (rsp.back_value),
		.entry_total (rsp.entry_total),
		.is_empty    (rsp.is_empty),
		.is_full     (rsp.is_full),
		.status      (rsp.status)
	);

endmodule

>>> sv/deq_checker.sv
module deq_checker import deq_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DATA_W-1:0] front_value,
	input logic signed [DATA_W-1:0] back_value,
	input logic [CNT_W-1:0]         entry_total,
	input logic                     is_empty,
	input logic                     is_full,
	input logic [1:0]               status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(front_value)
			&& $stable(back_value) && $stable(entry_total) && $stable(status))
		else $error("result word changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_total == '0))
			&& (is_full == (entry_total == CNT_W'(DEPTH))))
		else $error("empty or full flag disagrees with count");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> front_value == '0 && back_value == '0)
		else $error("empty queue reports nonzero values");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DONE || (status == ST_FULL && is_full)
			|| (status == ST_EMPTY && is_empty)))
		else $error("status does not match queue state");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted on consecutive cycles");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.front_value (rsp.front_value),
	.back_value  (rsp.back_value),
	.entry_total (rsp.entry_total),
	.is_empty    (rsp.is_empty),
	.is_full     (rsp.is_full),
	.status      (rsp.status)
);
